// ----- hdl/cfl_pkg.sv -----
// Shared types, opcodes and default sizes for the cmap format 4 glyph lookup.
`timescale 1ns / 1ps

package cfl_pkg;

    localparam int MAX_SEGMENTS_DEF = 256;
    localparam int ARRAY_WORDS_DEF  = 1024;

    localparam int COUNT_W = 9;
    localparam int SLOT_W  = 10;
    localparam int WORD_W  = 16;
    localparam int CODE_W  = 21;
    localparam int POS_W   = 19;

    localparam logic [1:0] OP_WR_SEG = 2'd0;
    localparam logic [1:0] OP_WR_ARR = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] segment_end;
        logic [WORD_W-1:0] segment_start;
        logic [WORD_W-1:0] segment_delta;
        logic [WORD_W-1:0] segment_range_offset;
        logic [WORD_W-1:0] array_word;
        logic [CODE_W-1:0] char_code;
    } t_in_beat;

    typedef struct packed {
        logic [WORD_W-1:0] glyph_index;
        logic              hit;
        logic              bad_index;
    } t_out_beat;

    typedef struct packed {
        logic [WORD_W-1:0] end_code;
        logic [WORD_W-1:0] start_code;
        logic [WORD_W-1:0] delta;
        logic [WORD_W-1:0] range_offset;
    } t_seg_entry;

    localparam int SEG_ENTRY_W = $bits(t_seg_entry);

endpackage

// ----- hdl/cfl_ram.sv -----
// Simple dual-port synchronous RAM, one write port and one registered read port.
`timescale 1ns / 1ps

module cfl_ram
    import cfl_pkg::*;
#(
    parameter int WIDTH = WORD_W,
    parameter int DEPTH = ARRAY_WORDS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/cmap_format4_glyph_lookup.sv -----
// Character code to glyph index lookup through a cmap format 4 segment table.
// Segment and glyph array writes pass from acceptance through the DONE state to the
// result register. A lookup passes through a load state and the segment scan; a miss
// or a delta-only hit then finishes, and a hit with a range offset checks its array
// position and, if it lies inside the array, reads the glyph array before finishing.
// An empty table goes straight to the DONE state. The segment scan reads one entry
// of the segment memory per cycle. One item is in work at a time, and a new item is
// accepted while the previous result still waits in the output register; a finished
// item waits in the DONE state for as long as this earlier result stays stalled.
// Table memories are not cleared by reset: load every segment below segment_count,
// and every array word that a lookup can reach, before looking up.
`timescale 1ns / 1ps

module cmap_format4_glyph_lookup
    import cfl_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int ARRAY_WORDS  = ARRAY_WORDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_beat           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_beat          o_out_data
);

    localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int ARR_AW = (ARRAY_WORDS > 1) ? $clog2(ARRAY_WORDS) : 1;
    localparam logic [POS_W-2:0] ARR_LIM = (POS_W-1)'(ARRAY_WORDS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_POS  = 3'd3;
    localparam logic [2:0] S_GRD  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [COUNT_W-1:0] r_seg_count;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic [COUNT_W-1:0] r_idx, n_idx;
    logic [CODE_W-1:0]  r_code, n_code;
    logic [WORD_W-1:0]  r_delta, n_delta;
    logic [POS_W-1:0]   r_pos, n_pos;
    t_out_beat          r_res, n_res;
    logic               r_out_valid;
    t_out_beat          r_out;

    logic               accept;
    logic               out_free;
    logic [COUNT_W-1:0] eff_cnt;
    logic [COUNT_W-1:0] idx_inc;
    logic               seg_we;
    logic               arr_we;
    logic [SEG_AW-1:0]  seg_raddr;
    logic [ARR_AW-1:0]  arr_raddr;
    logic [SEG_ENTRY_W-1:0] seg_rdata;
    logic [WORD_W-1:0]  arr_rdata;
    t_seg_entry         seg;
    t_seg_entry         seg_wr;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign eff_cnt  = (32'(r_seg_count) > MAX_SEGMENTS) ? COUNT_W'(MAX_SEGMENTS) : r_seg_count;
    assign idx_inc  = r_idx + COUNT_W'(1);

    assign seg_we = accept && (i_in_data.opcode == OP_WR_SEG)
                    && (32'(i_in_data.slot) < MAX_SEGMENTS);
    assign arr_we = accept && (i_in_data.opcode == OP_WR_ARR)
                    && (32'(i_in_data.slot) < ARRAY_WORDS);

    assign seg_wr.end_code     = i_in_data.segment_end;
    assign seg_wr.start_code   = i_in_data.segment_start;
    assign seg_wr.delta        = i_in_data.segment_delta;
    assign seg_wr.range_offset = i_in_data.segment_range_offset;

    assign seg_raddr = (r_state == S_CMP) ? SEG_AW'(idx_inc) : SEG_AW'(r_idx);
    assign arr_raddr = ARR_AW'(r_pos[POS_W-2:0]);
    assign seg       = t_seg_entry'(seg_rdata);

    cfl_ram #(
        .WIDTH (SEG_ENTRY_W),
        .DEPTH (MAX_SEGMENTS),
        .AW    (SEG_AW)
    ) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (seg_we),
        .i_waddr (SEG_AW'(i_in_data.slot)),
        .i_wdata (seg_wr),
        .i_raddr (seg_raddr),
        .o_rdata (seg_rdata)
    );

    cfl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ARRAY_WORDS),
        .AW    (ARR_AW)
    ) u_arr_ram (
        .i_clk   (i_clk),
        .i_we    (arr_we),
        .i_waddr (ARR_AW'(i_in_data.slot)),
        .i_wdata (i_in_data.array_word),
        .i_raddr (arr_raddr),
        .o_rdata (arr_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_code  = r_code;
        n_delta = r_delta;
        n_pos   = r_pos;
        n_res   = r_res;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res  = '0;
                    n_code = i_in_data.char_code;
                    n_cnt  = eff_cnt;
                    n_idx  = '0;
                    if (i_in_data.opcode == OP_LOOKUP && eff_cnt != '0) begin
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_LOAD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_code > CODE_W'(seg.end_code)) begin
                    if (idx_inc == r_cnt) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx = idx_inc;
                    end
                end else if (r_code[WORD_W-1:0] < seg.start_code) begin
                    n_state = S_DONE;
                end else begin
                    n_res.hit = 1'b1;
                    n_delta   = seg.delta;
                    if (seg.range_offset == '0) begin
                        n_res.glyph_index = r_code[WORD_W-1:0] + seg.delta;
                        n_state = S_DONE;
                    end else begin
                        n_pos = POS_W'(seg.range_offset[WORD_W-1:1])
                              + POS_W'(r_code[WORD_W-1:0] - seg.start_code)
                              - POS_W'(r_cnt - r_idx);
                        n_state = S_POS;
                    end
                end
            end
            S_POS: begin
                if (r_pos[POS_W-1] || r_pos[POS_W-2:0] >= ARR_LIM) begin
                    n_res.bad_index = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_GRD;
                end
            end
            S_GRD: begin
                n_res.glyph_index = (arr_rdata == '0) ? '0 : arr_rdata + r_delta;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seg_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_seg_count <= i_cfg_wdata;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_idx   <= n_idx;
        r_code  <= n_code;
        r_delta <= n_delta;
        r_pos   <= n_pos;
        r_res   <= n_res;
        if (r_state == S_DONE && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- dv/tb_cmap_format4_glyph_lookup.sv -----
`timescale 1ns / 1ps
// Self-checking testbench: cmap format 4 lookup against a segment-table scoreboard.

module tb_cmap_format4_glyph_lookup
    import cfl_pkg::*;
();

    localparam int SEGS  = MAX_SEGMENTS_DEF;
    localparam int WORDS = ARRAY_WORDS_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    class glyph_map_scoreboard;
        bit [WORD_W-1:0] end_code [SEGS];
        bit [WORD_W-1:0] start_code [SEGS];
        bit [WORD_W-1:0] delta [SEGS];
        bit [WORD_W-1:0] range_off [SEGS];
        bit [WORD_W-1:0] glyph_word [WORDS];
        bit              seg_loaded [SEGS];
        bit              word_loaded [WORDS];
        int unsigned     seg_count;
        t_out_beat       expected_glyphs [$];
        int unsigned     failures;
        int unsigned     lookups;
        int unsigned     hits;
        int unsigned     bad_lookups;

        function t_out_beat map_code(input logic [CODE_W-1:0] code, output bit reads_unloaded);
            t_out_beat       r;
            int unsigned     n;
            longint          pos;
            bit [WORD_W-1:0] g;
            r = '0;
            reads_unloaded = 1'b0;
            n = (seg_count > SEGS) ? SEGS : seg_count;
            for (int i = 0; i < n; i++) begin
                if (!seg_loaded[i]) reads_unloaded = 1'b1;
                if (code > CODE_W'(end_code[i])) continue;
                if (code < CODE_W'(start_code[i])) return r;
                r.hit = 1'b1;
                if (range_off[i] == '0) begin
                    r.glyph_index = code[WORD_W-1:0] + delta[i];
                end else begin
                    pos = longint'(range_off[i] >> 1) + longint'(code)
                        - longint'(start_code[i]) - longint'(n - i);
                    if (pos < 0 || pos >= WORDS) begin
                        r.bad_index = 1'b1;
                    end else begin
                        if (!word_loaded[pos]) reads_unloaded = 1'b1;
                        g = glyph_word[pos];
                        if (g != '0) begin
                            r.glyph_index = g + delta[i];
                        end
                    end
                end
                return r;
            end
            return r;
        endfunction

        function void note_item(t_in_beat beat);
            t_out_beat want;
            bit        skipped;
            want = '0;
            case (beat.opcode)
                OP_WR_SEG: begin
                    if (int'(beat.slot) < SEGS) begin
                        end_code[beat.slot]   = beat.segment_end;
                        start_code[beat.slot] = beat.segment_start;
                        delta[beat.slot]      = beat.segment_delta;
                        range_off[beat.slot]  = beat.segment_range_offset;
                        seg_loaded[beat.slot] = 1'b1;
                    end
                end
                OP_WR_ARR: begin
                    if (int'(beat.slot) < WORDS) begin
                        glyph_word[beat.slot]  = beat.array_word;
                        word_loaded[beat.slot] = 1'b1;
                    end
                end
                OP_LOOKUP: begin
                    want = map_code(beat.char_code, skipped);
                    lookups++;
                    if (want.hit) hits++;
                    if (want.bad_index) bad_lookups++;
                end
                default: ;
            endcase
            expected_glyphs.push_back(want);
        endfunction

        function void check_result(t_out_beat got);
            t_out_beat want;
            if (expected_glyphs.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected result beat: glyph %h hit %b bad_index %b",
                             $time, got.glyph_index, got.hit, got.bad_index);
                return;
            end
            want = expected_glyphs.pop_front();
            if (got.glyph_index !== want.glyph_index || got.hit !== want.hit
                    || got.bad_index !== want.bad_index) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: expected glyph %h hit %b bad %b, got glyph %h hit %b bad %b",
                             $time, want.glyph_index, want.hit, want.bad_index,
                             got.glyph_index, got.hit, got.bad_index);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    t_in_beat           in_beat = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_out_beat          out_beat;
    bit                 tx_gaps = 1'b1;
    bit                 rx_gaps = 1'b1;
    int unsigned        beats_sent = 0;
    glyph_map_scoreboard glyph_sb = new;

    cmap_format4_glyph_lookup i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_beat)
    );

    always #1 clk = ~clk;

    function automatic t_in_beat random_beat();
        t_in_beat b;
        b.opcode               = 2'($urandom_range(0, 3));
        b.slot                 = SLOT_W'($urandom);
        b.segment_end          = WORD_W'($urandom);
        b.segment_start        = WORD_W'($urandom);
        b.segment_delta        = WORD_W'($urandom);
        b.segment_range_offset = WORD_W'($urandom);
        b.array_word           = WORD_W'($urandom);
        b.char_code            = CODE_W'($urandom);
        return b;
    endfunction

    // hold the beat until accepted; valid stays high on return
    task automatic send_beat(input t_in_beat beat);
        int unsigned gap;
        gap = tx_gaps ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        glyph_sb.note_item(beat);
        beats_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (glyph_sb.expected_glyphs.size() != 0) @(posedge clk);
    endtask

    task automatic set_segment_count(input int unsigned value);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= COUNT_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        glyph_sb.seg_count = value;
    endtask

    task automatic write_segment(input int unsigned slot, input logic [WORD_W-1:0] seg_end,
                                 input logic [WORD_W-1:0] seg_start,
                                 input logic [WORD_W-1:0] seg_delta,
                                 input logic [WORD_W-1:0] seg_ro);
        t_in_beat b;
        b = random_beat();
        b.opcode               = OP_WR_SEG;
        b.slot                 = SLOT_W'(slot);
        b.segment_end          = seg_end;
        b.segment_start        = seg_start;
        b.segment_delta        = seg_delta;
        b.segment_range_offset = seg_ro;
        send_beat(b);
    endtask

    task automatic write_word(input int unsigned slot, input logic [WORD_W-1:0] value);
        t_in_beat b;
        b = random_beat();
        b.opcode     = OP_WR_ARR;
        b.slot       = SLOT_W'(slot);
        b.array_word = value;
        send_beat(b);
    endtask

    task automatic look_up(input logic [CODE_W-1:0] code);
        t_in_beat b;
        b = random_beat();
        b.opcode    = OP_LOOKUP;
        b.char_code = code;
        send_beat(b);
    endtask

    // when tidy, sorted segments ending at 0xFFFF, array-backed ones with their words loaded first; else random ones
    task automatic build_table(input int unsigned n, input bit tidy);
        int unsigned       stride;
        int unsigned       span;
        int unsigned       base;
        bit                backed;
        logic [WORD_W-1:0] seg_start;
        logic [WORD_W-1:0] seg_end;
        logic [WORD_W-1:0] seg_ro;
        stride = 65535 / n;
        for (int i = 0; i < n; i++) begin
            if (!tidy) begin
                write_segment(i, WORD_W'($urandom), WORD_W'($urandom), WORD_W'($urandom),
                              WORD_W'($urandom));
            end else begin
                backed = $urandom_range(0, 99) < ((n > 32) ? 10 : 50);
                span = backed ? $urandom_range(0, 7) : $urandom_range(0, stride / 2);
                seg_start = WORD_W'(i * stride + $urandom_range(0, stride / 4));
                seg_end = seg_start + WORD_W'(span);
                if (i == n - 1) begin
                    seg_end   = '1;
                    seg_start = WORD_W'(65535 - span);
                end
                seg_ro = '0;
                if (backed) begin
                    base = $urandom_range(0, WORDS - 8);
                    seg_ro = WORD_W'(2 * (n - i + base) + $urandom_range(0, 1));
                    for (int w = 0; w <= span; w++)
                        write_word(base + w,
                                   ($urandom_range(0, 7) == 0) ? WORD_W'(0) : WORD_W'($urandom));
                end
                write_segment(i, seg_end, seg_start, WORD_W'($urandom), seg_ro);
            end
        end
    endtask

    // retry, up to 12 times, until the scan only touches loaded entries; else fall back to an all-ones code
    function automatic logic [CODE_W-1:0] pick_code();
        logic [CODE_W-1:0] code;
        int unsigned       n;
        int unsigned       j;
        int unsigned       lo_c;
        int unsigned       hi_c;
        bit                unloaded;
        t_out_beat         probe;
        n = (glyph_sb.seg_count > SEGS) ? SEGS : glyph_sb.seg_count;
        for (int tries = 0; tries < 12; tries++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    if (n > 0) begin
                        j = $urandom_range(0, n - 1);
                        lo_c = glyph_sb.start_code[j];
                        hi_c = glyph_sb.end_code[j];
                        lo_c = (lo_c > 0) ? lo_c - 1 : 0;
                        hi_c = hi_c + 1;
                        code = CODE_W'($urandom_range(lo_c, hi_c));
                    end else begin
                        code = CODE_W'($urandom_range(0, 65535));
                    end
                end
                6, 7: code = CODE_W'($urandom_range(0, 65535));
                8:    code = CODE_W'($urandom);
                default: begin
                    case ($urandom_range(0, 4))
                        0:       code = '0;
                        1:       code = CODE_W'(16'hFFFF);
                        2:       code = CODE_W'(21'h10000);
                        3:       code = CODE_W'(21'h10FFFF);
                        default: code = '1;
                    endcase
                end
            endcase
            probe = glyph_sb.map_code(code, unloaded);
            if (!unloaded) return code;
        end
        return '1;
    endfunction

    task automatic run_lookups(input int unsigned how_many);
        t_in_beat b;
        for (int k = 0; k < how_many; k++) begin
            if (k > 0 && $urandom_range(0, 99) == 0) wait_drained();
            if ($urandom_range(0, 19) == 0) begin
                b = random_beat();
                case ($urandom_range(0, 2))
                    0:       b.opcode = OP_WR_SEG;
                    1:       b.opcode = OP_WR_ARR;
                    default: b.opcode = OP_UNUSED;
                endcase
                send_beat(b);
            end else begin
                look_up(pick_code());
            end
        end
    endtask

    initial begin
        int unsigned seg_cnt;
        bit          build;
        bit          tidy;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, unused opcode, ignored segment slots
        set_segment_count(0);
        look_up('0);
        look_up('1);
        send_beat('{opcode: OP_UNUSED, slot: '1, segment_end: '1, segment_start: '1,
                    segment_delta: '1, segment_range_offset: '1, array_word: '1,
                    char_code: '1});
        write_segment(1023, 16'h1234, 16'h0000, 16'h0001, 16'h0000);
        write_segment(SEGS, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000);

        // four segments: delta wrap, odd array offset, negative and far positions
        write_segment(0, 16'h0040, 16'h0020, 16'hFFF0, 16'h0000);
        write_segment(1, 16'h0105, 16'h0100, 16'h0005, 16'd47);
        write_segment(2, 16'h0200, 16'h01F0, 16'h0000, 16'h0002);
        write_segment(3, 16'hFFFF, 16'hFF00, 16'h0001, 16'hFFFF);
        write_word(20, 16'h1234);
        write_word(21, 16'h0000);
        write_word(22, 16'hFFFF);
        set_segment_count(4);
        look_up(CODE_W'(16'h0030));
        look_up(CODE_W'(16'h0010));
        look_up(CODE_W'(16'h0100));
        look_up(CODE_W'(16'h0101));
        look_up(CODE_W'(16'h0102));
        look_up(CODE_W'(16'h0150));
        look_up(CODE_W'(16'h01F0));
        look_up(CODE_W'(16'hFFFF));
        look_up(CODE_W'(21'h10000));

        for (int p = 0; p < 13; p++) begin
            case (p)
                0:  begin seg_cnt = 1;   build = 1'b1; tidy = 1'b1; end
                1:  begin seg_cnt = 2;   build = 1'b1; tidy = 1'b1; end
                2:  begin seg_cnt = 5;   build = 1'b1; tidy = 1'b1; end
                3:  begin seg_cnt = 8;   build = 1'b1; tidy = 1'b0; end
                4:  begin seg_cnt = 12;  build = 1'b1; tidy = 1'b1; end
                5:  begin seg_cnt = 16;  build = 1'b1; tidy = 1'b1; end
                6:  begin seg_cnt = 0;   build = 1'b0; tidy = 1'b0; end
                7:  begin seg_cnt = 256; build = 1'b1; tidy = 1'b1; end
                8:  begin seg_cnt = 300; build = 1'b0; tidy = 1'b0; end
                9:  begin seg_cnt = 511; build = 1'b0; tidy = 1'b0; end
                10: begin seg_cnt = 200; build = 1'b0; tidy = 1'b0; end
                11: begin seg_cnt = 30;  build = 1'b1; tidy = 1'b1; end
                default: begin seg_cnt = 3; build = 1'b1; tidy = 1'b0; end
            endcase
            tx_gaps = 1'($urandom_range(0, 1));
            rx_gaps = 1'($urandom_range(0, 1));
            if (build) build_table((seg_cnt > SEGS) ? SEGS : seg_cnt, tidy);
            set_segment_count(seg_cnt);
            run_lookups((p >= 7 && p <= 10) ? 45 : 64);
        end

        wait_drained();
        repeat (20) @(posedge clk);
        $display("Sent %0d beats (%0d lookups, %0d hits, %0d array positions out of range).",
                 beats_sent, glyph_sb.lookups, glyph_sb.hits, glyph_sb.bad_lookups);
        $display("Segment counts 0 through 511 over 13 table phases; %0d result errors.",
                 glyph_sb.failures);
        if (glyph_sb.failures == 0 && glyph_sb.expected_glyphs.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        int unsigned gap;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            gap = rx_gaps ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (out_valid !== 1'b1) @(posedge clk);
            glyph_sb.check_result(out_beat);
        end
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
